/* hdl/rc4fb_pkg.sv */
// Shared types and constants for the RC4 feedback stream cipher.
// No dependencies; imported by the controller, datapath and top level.
package rc4fb_pkg;

   localparam int PERM_DEPTH = 256;
   localparam logic [7:0] BYTE_MASK = 8'hFF;
   // Width that holds any effective key length up to the largest store (256).
   localparam int LEN_W = 9;
   localparam int CSR_ADDR_W = 3;
   localparam logic [5:0] KEY_LEN_RESET = 6'd16;
   // Register index, taken from csr_paddr[2].
   localparam logic REG_KEY_LENGTH = 1'b0;

   typedef enum logic [1:0] {
      MODE_KEY_LOAD = 2'd0,
      MODE_SCHEDULE = 2'd1,
      MODE_ENCRYPT  = 2'd2,
      MODE_DECRYPT  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_KEY_WR,
      OP_SCHED_START,
      OP_FILL,
      OP_K_RD,
      OP_K_RJ,
      OP_K_WI,
      OP_K_WJ,
      OP_K_FB,
      OP_K_FBL,
      OP_D_START,
      OP_D_RJ,
      OP_D_WI,
      OP_D_HOLD,
      OP_D_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic step_last;
      logic rsp_full;
   } dp_status_type;

endpackage

/* hdl/rc4fb_ctrl.sv */
// Sequencer for the RC4 feedback cipher: key load, key schedule, data step.
// Depends on rc4fb_pkg; drives rc4fb_datapath through dp_cmd_type.
module rc4fb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_mode,
   output logic                     req_ready,
   input  rc4fb_pkg::dp_status_type status,
   output rc4fb_pkg::dp_cmd_type    cmd
);
   import rc4fb_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_FILL  = 11'b000_0000_0010,
      ST_K_RD  = 11'b000_0000_0100,
      ST_K_RJ  = 11'b000_0000_1000,
      ST_K_WI  = 11'b000_0001_0000,
      ST_K_WJ  = 11'b000_0010_0000,
      ST_K_FB  = 11'b000_0100_0000,
      ST_K_FBL = 11'b000_1000_0000,
      ST_D_RJ  = 11'b001_0000_0000,
      ST_D_WI  = 11'b010_0000_0000,
      ST_D_OUT = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   mode_type  mode_v;

   assign mode_v    = mode_type'(req_mode);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (mode_v) inside
                  MODE_KEY_LOAD: begin
                     cmd.op = OP_KEY_WR;
                  end
                  MODE_SCHEDULE: begin
                     cmd.op   = OP_SCHED_START;
                     state_in = ST_FILL;
                  end
                  MODE_ENCRYPT, MODE_DECRYPT: begin
                     cmd.op   = OP_D_START;
                     state_in = ST_D_RJ;
                  end
                  default: begin
                     cmd.op = OP_NONE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            cmd.op = OP_FILL;
            if (status.step_last) begin
               state_in = ST_K_RD;
            end
         end
         ST_K_RD: begin
            cmd.op   = OP_K_RD;
            state_in = ST_K_RJ;
         end
         ST_K_RJ: begin
            cmd.op   = OP_K_RJ;
            state_in = ST_K_WI;
         end
         ST_K_WI: begin
            cmd.op   = OP_K_WI;
            state_in = ST_K_WJ;
         end
         ST_K_WJ: begin
            cmd.op   = OP_K_WJ;
            state_in = status.step_last ? ST_K_FB : ST_K_RD;
         end
         ST_K_FB: begin
            cmd.op   = OP_K_FB;
            state_in = ST_K_FBL;
         end
         ST_K_FBL: begin
            cmd.op   = OP_K_FBL;
            state_in = ST_IDLE;
         end
         ST_D_RJ: begin
            cmd.op   = OP_D_RJ;
            state_in = ST_D_WI;
         end
         ST_D_WI: begin
            cmd.op   = OP_D_WI;
            state_in = ST_D_OUT;
         end
         ST_D_OUT: begin
            // hold until the output register can take the result
            if (status.rsp_full) begin
               cmd.op = OP_D_HOLD;
            end else begin
               cmd.op   = OP_D_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/rc4fb_datapath.sv */
// Datapath for the RC4 feedback cipher: permutation RAM, key RAM, indexes,
// feedback byte and output register. Depends on rc4fb_pkg.
module rc4fb_datapath #(
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [5:0]               key_length,
   input  rc4fb_pkg::dp_cmd_type    cmd,
   output rc4fb_pkg::dp_status_type status,
   input  logic [1:0]               req_mode,
   input  logic [4:0]               req_key_index,
   input  logic [7:0]               req_byte_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_byte_out
);
   import rc4fb_pkg::*;

   localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

   logic [7:0]        perm_mem_ff [PERM_DEPTH];
   logic [7:0]        key_mem_ff  [MAX_KEY_BYTES];
   logic [7:0]        perm_rd_ff;
   logic [7:0]        key_rd_ff;

   logic [7:0]        step_ff, step_in;
   logic [7:0]        mix_ff, mix_in;
   logic [7:0]        fb_ff, fb_in;
   logic [KIDX_W-1:0] k_ff, k_in;
   logic [7:0]        si_ff, si_in;
   logic [7:0]        sj_ff, sj_in;
   logic [7:0]        t_ff, t_in;
   logic [7:0]        data_ff, data_in;
   logic              dec_ff, dec_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   logic              perm_we;
   logic [7:0]        perm_waddr, perm_wdata, perm_raddr;
   logic              key_we;
   logic [KIDX_W-1:0] key_waddr, key_raddr;

   logic [LEN_W-1:0]  kl_ext, max_ext, len_eff, k_p1, kidx_ext;
   logic [KIDX_W-1:0] k_next;
   logic [7:0]        step_p1, j_sum, t_sum, ks, res;

   // effective key length, clamped to 1..MAX_KEY_BYTES
   assign kl_ext  = LEN_W'(key_length);
   assign max_ext = LEN_W'(MAX_KEY_BYTES);
   always_comb begin
      if (kl_ext == '0) begin
         len_eff = LEN_W'(1);
      end else if (kl_ext > max_ext) begin
         len_eff = max_ext;
      end else begin
         len_eff = kl_ext;
      end
   end

   assign k_p1     = LEN_W'(k_ff) + LEN_W'(1);
   assign k_next   = (k_p1 >= len_eff) ? '0 : k_p1[KIDX_W-1:0];
   assign kidx_ext = LEN_W'(req_key_index);
   assign step_p1  = 8'(step_ff + 8'd1);

   always_comb begin
      step_in      = step_ff;
      mix_in       = mix_ff;
      fb_in        = fb_ff;
      k_in         = k_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      data_in      = data_ff;
      dec_in       = dec_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      perm_we      = 1'b0;
      perm_waddr   = step_ff;
      perm_wdata   = perm_rd_ff;
      perm_raddr   = t_ff;
      key_we       = 1'b0;
      key_waddr    = kidx_ext[KIDX_W-1:0];
      key_raddr    = k_ff;
      j_sum        = 8'(mix_ff + perm_rd_ff);
      t_sum        = 8'(si_ff + perm_rd_ff);
      ks           = perm_rd_ff;
      res          = data_ff ^ ks ^ fb_ff;
      unique case (cmd.op)
         OP_KEY_WR: begin
            key_we = (kidx_ext < max_ext);
         end
         OP_SCHED_START: begin
            step_in = '0;
            mix_in  = '0;
            k_in    = '0;
         end
         OP_FILL: begin
            perm_we    = 1'b1;
            perm_wdata = step_ff;
            step_in    = step_p1;
         end
         OP_K_RD: begin
            perm_raddr = step_ff;
         end
         OP_K_RJ: begin
            si_in      = perm_rd_ff;
            j_sum      = 8'(mix_ff + key_rd_ff + perm_rd_ff);
            mix_in     = j_sum;
            perm_raddr = j_sum;
         end
         OP_K_WI: begin
            perm_we = 1'b1;
         end
         OP_K_WJ: begin
            perm_we    = 1'b1;
            perm_waddr = mix_ff;
            perm_wdata = si_ff;
            step_in    = step_p1;
            k_in       = k_next;
         end
         OP_K_FB: begin
            key_raddr = '0;
         end
         OP_K_FBL: begin
            fb_in   = key_rd_ff;
            step_in = '0;
            mix_in  = '0;
         end
         OP_D_START: begin
            data_in    = req_byte_in;
            dec_in     = (req_mode == MODE_DECRYPT);
            step_in    = step_p1;
            perm_raddr = step_p1;
         end
         OP_D_RJ: begin
            si_in      = perm_rd_ff;
            mix_in     = j_sum;
            perm_raddr = j_sum;
         end
         OP_D_WI: begin
            // S[i] <= S[j]; read S[S[i]+S[j]] in the same cycle
            perm_we    = 1'b1;
            sj_in      = perm_rd_ff;
            t_in       = t_sum;
            perm_raddr = t_sum;
         end
         OP_D_HOLD: begin
            perm_raddr = t_ff;
         end
         OP_D_OUT: begin
            perm_we    = 1'b1;
            perm_waddr = mix_ff;
            perm_wdata = si_ff;
            // forward the swap: S[j] is written last, so it wins
            if (t_ff == mix_ff) begin
               ks = si_ff;
            end else if (t_ff == step_ff) begin
               ks = sj_ff;
            end else begin
               ks = perm_rd_ff;
            end
            res          = data_ff ^ ks ^ fb_ff;
            fb_in        = fb_ff ^ (dec_ff ? res : data_ff);
            rsp_byte_in  = res;
            rsp_valid_in = 1'b1;
         end
         default: begin
            perm_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem_ff[perm_waddr] <= perm_wdata;
      end
      perm_rd_ff <= perm_mem_ff[perm_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[key_waddr] <= req_byte_in;
      end
      key_rd_ff <= key_mem_ff[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         mix_ff       <= '0;
         fb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         mix_ff       <= mix_in;
         fb_ff        <= fb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      data_ff     <= data_in;
      dec_ff      <= dec_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign status.step_last = (step_ff == BYTE_MASK);
   assign status.rsp_full  = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = rsp_byte_ff;

endmodule

/* hdl/rc4_feedback_stream_cipher.sv */
// Top level of the RC4 stream cipher with plaintext feedback.
// Depends on rc4fb_pkg, rc4fb_ctrl and rc4fb_datapath; holds the CSR port.
//
//  channel   direction  transfer when          payload
//  req_      in         req_valid & req_ready  mode, key_index, byte_in
//  rsp_      out        rsp_valid & rsp_ready  byte_out (modes 2 and 3 only)
//  csr_      in/out     psel&penable&pwrite    key_length at address 0
//
// Key load (mode 0) writes one key byte. A data byte (modes 2, 3) is paced
// by the single-port-write permutation RAM (read S[i], read S[j], swap and
// read S[t], write back). Key schedule (mode 1): start, table fill, a pass
// of reads and writes per entry and the feedback load, again bound by the
// RAM port. Reset clears i, j, feedback and handshake state; the permutation
// table is undefined until a schedule runs. A data result waits in the output
// register; a second stalls in its last cycle until the first is transferred.
module rc4_feedback_stream_cipher #(
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_mode,
   input  logic [4:0]                       req_key_index,
   input  logic [7:0]                       req_byte_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_byte_out,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rc4fb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import rc4fb_pkg::*;

   logic [5:0]    key_length_ff;
   logic          csr_wr;
   dp_cmd_type    cmd;
   dp_status_type status;

   // CSR: one register, key_length, word-aligned at address 0
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_RESET;
      end else if (csr_wr && (csr_paddr[2] == REG_KEY_LENGTH)) begin
         key_length_ff <= csr_pwdata[5:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_KEY_LENGTH) begin
         csr_prdata = {26'd0, key_length_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   rc4fb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rc4fb_datapath #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .key_length    (key_length_ff),
      .cmd           (cmd),
      .status        (status),
      .req_mode      (req_mode),
      .req_key_index (req_key_index),
      .req_byte_in   (req_byte_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_byte_out  (rsp_byte_out)
   );

`ifndef ASSERT_OFF
   // a result only appears out of the final data-step cycle
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.op == OP_D_OUT))
      else $error("result raised without a data step");

   // the output register is never overwritten while a result waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_D_OUT) |-> !(rsp_valid && !rsp_ready))
      else $error("pending result overwritten");

   // after a data byte or schedule transfer the block is busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_mode != MODE_KEY_LOAD)) |=> !req_ready)
      else $error("ready while a step is in progress");
`endif

endmodule
